@@ rtl/core/ascp_pkg.sv @@
// Shared types and constants for the serial speed command PWM core.
// Holds the character codes, the keyword and the classified item format.
// No dependencies.
package ascp_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_DC3   = 8'h13;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int KW_LEN = 5;
	localparam logic [7:0] KEYWORD [KW_LEN] = '{8'h73, 8'h70, 8'h65, 8'h65, 8'h64};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Byte or tick, already sorted into the classes the parser needs
	typedef struct packed {
		logic              is_tick;
		logic              is_zero;
		logic              is_term;
		logic              is_delim;
		logic              is_space;
		logic              is_sign;
		logic              is_minus;
		logic              is_digit;
		logic [3:0]        digit;
		logic [KW_LEN-1:0] kw_eq;
	} ascp_item_t;

endpackage

@@ rtl/core/ascp_if.sv @@
// Valid/ready channel interfaces for the serial speed command PWM core.
// Input channel carries command and rx_byte, output channel pwm_level and duty.
// No dependencies.
interface ascp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface ascp_out_if;
	logic       valid;
	logic       ready;
	logic       pwm_level;
	logic [7:0] duty;

	modport source (output valid, output pwm_level, output duty, input ready);
	modport sink (input valid, input pwm_level, input duty, output ready);
endinterface

@@ rtl/core/ascp_front.sv @@
// Front stage: accept input items and classify each byte into a registered item.
// Depends on ascp_pkg and ascp_in_if.
module ascp_front import ascp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ascp_in_if.sink    rx_ch,
	output logic       item_valid,
	output ascp_item_t item,
	input  logic       item_ready
);

	logic       valid_s1;
	ascp_item_t item_s1;
	ascp_item_t cls;
	logic [7:0] ch;

	assign ch = rx_ch.rx_byte;

	always_comb begin
		cls          = '0;
		cls.is_tick  = rx_ch.command;
		cls.is_zero  = (ch == 8'h00);
		cls.is_term  = (ch == CH_CLOSE) || (ch == CH_LF) || (ch == CH_DC3);
		cls.is_delim = (ch == CH_OPEN) || (ch == CH_CLOSE);
		cls.is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		cls.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		cls.digit    = ch[3:0];
		for (int i = 0; i < KW_LEN; i++) begin
			cls.kw_eq[i] = (ch == KEYWORD[i]);
		end
	end

	// Hold the stage while the queue is full
	assign rx_ch.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ch.ready) begin
			valid_s1 <= rx_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ch.ready && rx_ch.valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

@@ rtl/core/ascp_queue.sv @@
// Short FIFO of classified items between the front and back stages.
// Depends on ascp_pkg.
module ascp_queue import ascp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  ascp_item_t push_item,
	output logic       push_ready,
	output logic       pop_valid,
	output ascp_item_t pop_item,
	input  logic       pop_ready
);

	ascp_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QPTR_W:0]        count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/core/ascp_back.sv @@
// Back stage: run the line parser and the PWM counter, register each result.
// Depends on ascp_pkg and ascp_out_if.
module ascp_back import ascp_pkg::*; #(
	parameter int LINE_CAPACITY = 50,
	parameter int PWM_PERIOD    = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  ascp_item_t item,
	output logic       item_ready,
	ascp_out_if.source res_ch
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);

	typedef enum logic [2:0] {
		PH_LEAD, PH_NAME, PH_GAP, PH_SPACE, PH_DIGITS, PH_ARGDONE, PH_IGNORE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [2:0]         match_q, match_n;
	logic               mismatch_q, mismatch_n;
	logic [8:0]         accum_q, accum_n;
	logic               neg_q, neg_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic               trunc_q, trunc_n;
	logic [7:0]         tick_q, tick_n;
	logic               level_q, level_n;
	logic [7:0]         duty_q, duty_n;
	logic               out_valid_q;

	logic [8:0]         cnt_next;
	logic [7:0]         kw_pad;
	logic [11:0]        prod;
	logic               take;

	assign item_ready = !out_valid_q || res_ch.ready;
	assign take       = item_valid && item_ready;
	assign kw_pad     = {3'b000, item.kw_eq};
	assign cnt_next   = {1'b0, tick_q} + 9'd1;
	assign prod       = 12'(accum_q) * 12'd10 + {8'h00, item.digit};

	always_comb begin
		phase_n    = phase_q;
		match_n    = match_q;
		mismatch_n = mismatch_q;
		accum_n    = accum_q;
		neg_n      = neg_q;
		len_n      = len_q;
		trunc_n    = trunc_q;
		tick_n     = tick_q;
		level_n    = level_q;
		duty_n     = duty_q;

		if (item.is_tick) begin
			if (cnt_next <= {1'b0, duty_q}) begin
				level_n = 1'b1;
			end else if (cnt_next < 9'(PWM_PERIOD)) begin
				level_n = 1'b0;
			end
			if (cnt_next >= 9'(PWM_PERIOD)) begin
				tick_n = '0;
			end else begin
				tick_n = cnt_next[7:0];
			end
		end else begin
			if (len_q < LEN_W'(LINE_CAPACITY - 1)) begin
				len_n = len_q + 1'b1;
				if (!trunc_q) begin
					if (item.is_zero) begin
						trunc_n = 1'b1;
					end else begin
						case (phase_q)
							PH_LEAD, PH_NAME: begin
								if (item.is_delim) begin
									if (phase_q == PH_NAME) begin
										phase_n = (!mismatch_q && match_q == 3'(KW_LEN)) ?
											PH_GAP : PH_IGNORE;
									end
								end else begin
									phase_n = PH_NAME;
									if (match_q < 3'(KW_LEN) && kw_pad[match_q]) begin
										match_n = match_q + 1'b1;
									end else begin
										mismatch_n = 1'b1;
									end
								end
							end
							PH_GAP, PH_SPACE: begin
								// A non-delimiter in the gap starts the argument
								if (item.is_delim) begin
									if (phase_q == PH_SPACE) begin
										phase_n = PH_ARGDONE;
									end
								end else if (item.is_space) begin
									phase_n = PH_SPACE;
								end else if (item.is_sign) begin
									neg_n   = item.is_minus;
									phase_n = PH_DIGITS;
								end else if (item.is_digit) begin
									accum_n = {5'b00000, item.digit};
									phase_n = PH_DIGITS;
								end else begin
									phase_n = PH_ARGDONE;
								end
							end
							PH_DIGITS: begin
								if (item.is_digit) begin
									accum_n = (prod > 12'd256) ? 9'd256 : prod[8:0];
								end else begin
									phase_n = PH_ARGDONE;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			if (item.is_term) begin
				if (phase_n == PH_SPACE || phase_n == PH_DIGITS || phase_n == PH_ARGDONE) begin
					if (neg_n && accum_n != '0) begin
						duty_n = '0;
					end else begin
						duty_n = accum_n[8] ? 8'hff : accum_n[7:0];
					end
				end
				phase_n    = PH_LEAD;
				match_n    = '0;
				mismatch_n = 1'b0;
				accum_n    = '0;
				neg_n      = 1'b0;
				len_n      = '0;
				trunc_n    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			match_q     <= '0;
			mismatch_q  <= 1'b0;
			accum_q     <= '0;
			neg_q       <= 1'b0;
			len_q       <= '0;
			trunc_q     <= 1'b0;
			tick_q      <= '0;
			level_q     <= 1'b0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q    <= phase_n;
				match_q    <= match_n;
				mismatch_q <= mismatch_n;
				accum_q    <= accum_n;
				neg_q      <= neg_n;
				len_q      <= len_n;
				trunc_q    <= trunc_n;
				tick_q     <= tick_n;
				level_q    <= level_n;
				duty_q     <= duty_n;
			end
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.pwm_level = level_q;
	assign res_ch.duty      = duty_q;

endmodule

@@ rtl/core/ascii_speed_command_pwm_core.sv @@
// Top level of the serial speed command decoder with software PWM output.
// Depends on ascp_pkg, ascp_if, ascp_front, ascp_queue and ascp_back.
//
// Usage:
//   rx_ch carries one item per transfer: command = 0 delivers a received
//   byte in rx_byte, command = 1 is a PWM timer tick (rx_byte ignored).
//   Bytes build a line closed by ')', LF or 0x13; a line "speed(N)" sets
//   the duty to N clamped to 0..255. Ticks step the PWM counter.
//   res_ch returns exactly one transfer per input item: pwm_level and duty
//   as they stand after that item.
// Pipeline: the transfer loads the classify register, then the item is
//   written into the queue, then the back stage pops it and loads the
//   result register.
// Throughput: one item per cycle while res_ch is ready; the parser and PWM
//   counter update together in the back stage, so nothing else throttles a steady stream.
// Reset (arst_n low): counter, level and duty go to zero, the parser starts
//   a fresh line, the queue empties and no result is pending.
// Receiver stall: the result register holds; the back stage stops popping,
//   the four-entry queue and the classify register fill, and only then does
//   rx_ch.ready drop.
module ascii_speed_command_pwm_core import ascp_pkg::*; #(
	parameter int LINE_CAPACITY = 50,
	parameter int PWM_PERIOD    = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	ascp_in_if.sink    rx_ch,
	ascp_out_if.source res_ch
);

	// Front to queue
	logic       fq_valid;
	logic       fq_ready;
	ascp_item_t fq_item;

	// Queue to back
	logic       qb_valid;
	logic       qb_ready;
	ascp_item_t qb_item;

	ascp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_ch      (rx_ch),
		.item_valid (fq_valid),
		.item       (fq_item),
		.item_ready (fq_ready)
	);

	ascp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_item  (fq_item),
		.push_ready (fq_ready),
		.pop_valid  (qb_valid),
		.pop_item   (qb_item),
		.pop_ready  (qb_ready)
	);

	ascp_back #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.PWM_PERIOD    (PWM_PERIOD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qb_valid),
		.item       (qb_item),
		.item_ready (qb_ready),
		.res_ch     (res_ch)
	);

endmodule

@@ dv/ascii_speed_command_pwm_core_tb.sv @@
// Self-checking testbench for ascii_speed_command_pwm_core: serial speed lines and PWM ticks.
// Drives rx_ch from a backlog queue, checks every res_ch transfer against a local line parser.
// Depends on ascp_pkg, ascp_if and the core RTL.
module ascii_speed_command_pwm_core_tb import ascp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CAPACITY = 50;
	localparam int PWM_PERIOD    = 255;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int LONG_STALL    = 300;
	localparam int DRAIN_CYCLES  = 12;

	localparam logic [7:0] CH_NUL = 8'h00;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       pwm_level;
		logic [7:0] duty;
	} drive_state_t;

	// Where the parser stands within the current line
	typedef enum logic [2:0] {
		PH_LEAD, PH_NAME, PH_GAP, PH_SPACE, PH_DIGITS, PH_ARGDONE, PH_IGNORE
	} line_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	ascp_in_if  rx_if ();
	ascp_out_if res_if ();

	ascii_speed_command_pwm_core #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.PWM_PERIOD   (PWM_PERIOD)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx_ch (rx_if),
		.res_ch(res_if)
	);

	always #10 clk = ~clk;

	// Items waiting to be offered, and the drive states still owed by the core
	rx_item_t     rx_backlog [$];
	drive_state_t due_states [$];

	int unsigned pushed_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned error_count    = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_idle_pct  = 0;
	int unsigned stall_requests = 0;
	int unsigned stall_served   = 0;
	int unsigned stall_left     = 0;

	rx_item_t     next_item;
	drive_state_t owed;

	// Local copy of the core state
	logic [7:0]  pwm_ticks;
	logic        pwm_out;
	logic [7:0]  duty_now;
	line_phase_t phase;
	logic [2:0]  kw_pos;
	logic        kw_bad;
	logic [8:0]  arg_value;
	logic        arg_negative;
	logic [5:0]  line_len;
	logic        line_cut;

	function automatic logic is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	function void start_line();
		phase        = PH_LEAD;
		kw_pos       = '0;
		kw_bad       = 1'b0;
		arg_value    = '0;
		arg_negative = 1'b0;
		line_len     = '0;
		line_cut     = 1'b0;
	endfunction

	function void reset_speed_model();
		pwm_ticks = '0;
		pwm_out   = 1'b0;
		duty_now  = '0;
		start_line();
	endfunction

	function void parse_byte(input logic [7:0] ch);
		logic delim;
		int   grown;
		delim = (ch == CH_OPEN) || (ch == CH_CLOSE);
		case (phase)
			PH_LEAD, PH_NAME: begin
				if (delim) begin
					// a delimiter ends the name token; leading delimiters are skipped
					if (phase == PH_NAME)
						phase = (!kw_bad && kw_pos == KW_LEN) ? PH_GAP : PH_IGNORE;
				end else begin
					phase = PH_NAME;
					if (kw_pos < KW_LEN && ch == KEYWORD[kw_pos])
						kw_pos = kw_pos + 1'b1;
					else
						kw_bad = 1'b1;
				end
			end
			PH_GAP, PH_SPACE: begin
				if (delim) begin
					if (phase == PH_SPACE)
						phase = PH_ARGDONE;
				end else begin
					phase = PH_SPACE;
					if (is_blank(ch)) begin
						// hold: still skipping whitespace
					end else if (ch == CH_MINUS || ch == CH_PLUS) begin
						arg_negative = (ch == CH_MINUS);
						phase        = PH_DIGITS;
					end else if (is_digit(ch)) begin
						arg_value = 9'(ch - CH_ZERO);
						phase     = PH_DIGITS;
					end else begin
						phase = PH_ARGDONE;
					end
				end
			end
			PH_DIGITS: begin
				if (is_digit(ch)) begin
					// saturate as the number is read
					grown     = int'(arg_value) * 10 + int'(ch - CH_ZERO);
					arg_value = (grown > 256) ? 9'd256 : 9'(grown);
				end else begin
					phase = PH_ARGDONE;
				end
			end
			default: ;
		endcase
	endfunction

	function void close_line();
		if (phase == PH_SPACE || phase == PH_DIGITS || phase == PH_ARGDONE) begin
			if (arg_negative && arg_value != 0)
				duty_now = '0;
			else
				duty_now = (arg_value > 255) ? 8'd255 : arg_value[7:0];
		end
		start_line();
	endfunction

	function drive_state_t step_speed_model(input rx_item_t item);
		int count;
		if (item.command) begin
			count = int'(pwm_ticks) + 1;
			if (count <= int'(duty_now))
				pwm_out = 1'b1;
			else if (count < PWM_PERIOD)
				pwm_out = 1'b0;
			pwm_ticks = (count >= PWM_PERIOD) ? 8'd0 : 8'(count);
		end else begin
			if (line_len < LINE_CAPACITY - 1) begin
				line_len = line_len + 1'b1;
				if (!line_cut) begin
					if (item.rx_byte == CH_NUL)
						line_cut = 1'b1;
					else
						parse_byte(item.rx_byte);
				end
			end
			// a terminator closes the line even past capacity
			if (item.rx_byte == CH_CLOSE || item.rx_byte == CH_LF || item.rx_byte == CH_DC3)
				close_line();
		end
		return '{pwm_level: pwm_out, duty: duty_now};
	endfunction

	// Sender: advance to the next backlog item once the current one transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid   <= 1'b0;
			rx_if.command <= 1'b0;
			rx_if.rx_byte <= '0;
			reset_speed_model();
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				due_states.push_back(step_speed_model('{command: rx_if.command,
					rx_byte: rx_if.rx_byte}));
				accepted_count++;
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item     = rx_backlog.pop_front();
					rx_if.valid   <= 1'b1;
					rx_if.command <= next_item.command;
					rx_if.rx_byte <= next_item.rx_byte;
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transfer, hold ready low during a long stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (due_states.size() == 0) begin
					$error("unexpected result: pwm_level %0d, duty %0d",
						res_if.pwm_level, res_if.duty);
					error_count++;
				end else begin
					owed = due_states.pop_front();
					if (res_if.pwm_level !== owed.pwm_level) begin
						$error("pwm_level: expected %0d, actual %0d",
							owed.pwm_level, res_if.pwm_level);
						error_count++;
					end
					if (res_if.duty !== owed.duty) begin
						$error("duty: expected %0d, actual %0d", owed.duty, res_if.duty);
						error_count++;
					end
				end
			end
			if (stall_served != stall_requests) begin
				stall_served = stall_requests;
				stall_left   = LONG_STALL;
				res_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ascii_speed_command_pwm_core_tb NOT OK");
			$finish;
		end
	end

	task automatic push_item(input logic command, input logic [7:0] rx_byte);
		rx_backlog.push_back('{command: command, rx_byte: rx_byte});
		pushed_count++;
	endtask

	task automatic push_byte(input logic [7:0] ch);
		push_item(1'b0, ch);
	endtask

	task automatic push_text(input string text);
		for (int i = 0; i < text.len(); i++)
			push_byte(text[i]);
	endtask

	task automatic push_ticks(input int count);
		repeat (count) push_item(1'b1, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] pick_blank();
		int pick;
		pick = $urandom_range(0, 5);
		return (pick == 0) ? CH_SPACE : 8'(CH_TAB + pick - 1);
	endfunction

	// Build one speed command; broken ones carry a single flaw
	task automatic push_speed_line(input bit broken);
		logic [7:0] line [$];
		string      digits;
		int         flaw;
		int         value;
		flaw = broken ? $urandom_range(0, 4) : -1;
		if ($urandom_range(0, 7) == 0)
			line.push_back(CH_OPEN);
		for (int i = 0; i < KW_LEN; i++)
			line.push_back(KEYWORD[i]);
		if (flaw == 0)
			line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(33, 126));
		if (flaw == 1)
			line.push_back(8'($urandom_range(97, 122)));
		if (flaw != 2)
			line.push_back(CH_OPEN);
		if ($urandom_range(0, 7) == 0)
			line.push_back(CH_OPEN);
		if (flaw == 3)
			repeat (40 + $urandom_range(0, 8)) line.push_back(CH_SPACE);
		repeat ($urandom_range(0, 2)) line.push_back(pick_blank());
		case ($urandom_range(0, 9))
			0, 1:    line.push_back(CH_MINUS);
			2:       line.push_back(CH_PLUS);
			default: ;
		endcase
		if ($urandom_range(0, 15) != 0) begin
			value  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 99999);
			digits = $sformatf("%0d", value);
			if ($urandom_range(0, 7) == 0)
				digits = {"00", digits};
			for (int i = 0; i < digits.len(); i++)
				line.push_back(digits[i]);
		end
		if ($urandom_range(0, 7) == 0)
			line.push_back(8'($urandom_range(33, 126)));
		if (flaw == 4)
			line.insert($urandom_range(0, line.size()), CH_NUL);
		case ($urandom_range(0, 5))
			0:       line.push_back(CH_LF);
			1:       line.push_back(CH_DC3);
			default: line.push_back(CH_CLOSE);
		endcase
		foreach (line[i])
			push_byte(line[i]);
	endtask

	// Good commands and tick bursts, with broken lines and raw noise mixed in
	task automatic push_random(input int count);
		int target;
		int pick;
		target = pushed_count + count;
		while (pushed_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				push_ticks($urandom_range(256, 300));
			else if (pick < 35)
				push_ticks($urandom_range(1, 40));
			else if (pick < 75)
				push_speed_line(1'b0);
			else if (pick < 90)
				push_speed_line(1'b1);
			else
				repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_drained();
		while (accepted_count != pushed_count || due_states.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		rx_if.valid   = 1'b0;
		rx_if.command = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready  = 1'b0;
		arst_n        = 1'b0;
		send_idle_pct = 7;
		recv_idle_pct = 73;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: saturation, signs, missing and empty arguments, bad names,
		// zero byte, over-long lines, every terminator, full PWM periods
		push_ticks(3);
		push_text("speed(255)");
		push_ticks(2);
		push_text("speed(300)");
		push_text("speed(-5)");
		push_text("speed(77)");
		push_text("speed(-0)");
		push_text("speed(+7)");
		push_text("speed()");
		push_text("speed");
		push_byte(CH_LF);
		push_text("speed(");
		push_byte(CH_LF);
		push_text("speed(12");
		push_byte(CH_DC3);
		push_text("speed(abc)");
		push_text("spee(9)");
		push_text("speedy(9)");
		push_text("(speed(( \t42)");
		push_text("spe");
		push_byte(CH_NUL);
		push_text("ed(9)");
		push_text("speed(");
		repeat (43) push_byte(CH_SPACE);
		push_text("1)");
		repeat (60) push_byte(8'($urandom_range(65, 90)));
		push_byte(CH_LF);
		push_text("speed(100)");
		push_ticks(300);
		push_random(500);
		wait_drained();

		send_idle_pct = 73;
		recv_idle_pct = 7;
		push_random(500);
		wait_drained();

		// No idling; park the receiver so the core backs up into rx_ch
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(450);
		stall_requests++;
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ascii_speed_command_pwm_core_tb OK");
		else
			$display("ascii_speed_command_pwm_core_tb NOT OK");
		$finish;
	end

endmodule

@@ ascii_speed_command_pwm_core.f @@
rtl/core/ascp_pkg.sv
rtl/core/ascp_if.sv
rtl/core/ascp_front.sv
rtl/core/ascp_queue.sv
rtl/core/ascp_back.sv
rtl/core/ascii_speed_command_pwm_core.sv
dv/ascii_speed_command_pwm_core_tb.sv
